// File: sv/cache_replacement_policy_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cache replacement policy block
// ---------------------------------------------------------------------------
`ifndef CACHE_REPLACEMENT_POLICY_DEFINES_SVH
`define CACHE_REPLACEMENT_POLICY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/crp_pkg.sv
// ---------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the cache replacement policy block.
// ---------------------------------------------------------------------------
package crp_pkg;

  // field widths
  localparam int unsigned IN_KEY_W   = 48;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd1;

  // policy codes
  localparam logic [MODE_W-1:0] MODE_LRU = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LFU = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWO = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch key, clear scan trackers
    logic rd_en;   // read both stores at the scan address
    logic commit;  // apply update, load result
  } crp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item
  } crp_stat_t;

endpackage

// File: sv/crp_ram.sv
// ---------------------------------------------------------------------------
// crp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module crp_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/crp_ctrl.sv
// ---------------------------------------------------------------------------
// crp_ctrl
// Sequencer: accept an item, scan every slot of both stores, commit.
// ---------------------------------------------------------------------------
`include "cache_replacement_policy_defines.svh"

module crp_ctrl #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  crp_pkg::crp_stat_t       stat,
  output crp_pkg::crp_cmd_t        cmd,
  output logic [$clog2(SLOTS)-1:0] rd_addr
);

  localparam int unsigned IW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [IW-1:0]  addr_r, addr_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      S_IDLE: begin
        addr_nxt = '0;
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == IW'(SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cmd.start  = in_tvalid && (state_r == S_IDLE);
  assign cmd.rd_en  = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && stat.out_free;
  assign rd_addr    = addr_r;

  `CRP_ASSERT_NXT(a_start_scans, clk, rst_n, cmd.start, state_r == S_SCAN, "accepted item did not start a scan")
  `CRP_ASSERT_NXT(a_commit_once, clk, rst_n, cmd.commit, state_r == S_IDLE && !cmd.commit, "commit repeated")
  `CRP_ASSERT_IMP(a_no_read_idle, clk, rst_n, cmd.rd_en, !in_tready && !cmd.commit, "store read outside scan")

endmodule

// File: sv/crp_dp.sv
// ---------------------------------------------------------------------------
// crp_dp
// Datapath: configuration, store RAMs, valid bits, scan trackers, update.
// ---------------------------------------------------------------------------
module crp_dp #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned KEY_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [crp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [crp_pkg::IN_DATA_W-1:0]      in_tdata,
  input  crp_pkg::crp_cmd_t                  cmd,
  input  logic [$clog2(SLOTS)-1:0]           rd_addr,
  output crp_pkg::crp_stat_t                 stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [crp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned FW = $clog2(SLOTS + 1);
  localparam int unsigned KW = (KEY_BITS < crp_pkg::IN_KEY_W) ? KEY_BITS : crp_pkg::IN_KEY_W;
  localparam int unsigned CW = (FW > crp_pkg::CAP_W) ? FW : crp_pkg::CAP_W;
  localparam int unsigned SW = crp_pkg::STAMP_W;
  localparam int unsigned NW = crp_pkg::COUNT_W;
  localparam int unsigned EW = KW + NW + SW;

  // configuration
  logic [crp_pkg::MODE_W-1:0] mode_r;
  logic [crp_pkg::CAP_W-1:0]  cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= crp_pkg::MODE_LRU;
      cap_r  <= crp_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        crp_pkg::REG_POLICY_MODE: mode_r <= cfg_wdata[crp_pkg::MODE_W-1:0];
        crp_pkg::REG_CAPACITY:    cap_r  <= cfg_wdata[crp_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  logic lfu, two;
  assign lfu = (mode_r == crp_pkg::MODE_LFU);
  assign two = (mode_r == crp_pkg::MODE_TWO);

  // effective capacity: zero counts as one, clipped to SLOTS
  logic [CW-1:0] cap_w, eff_cap;
  always_comb begin
    cap_w = CW'(cap_r);
    if (cap_w == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CW'(SLOTS)) begin
      eff_cap = CW'(SLOTS);
    end else begin
      eff_cap = cap_w;
    end
  end

  // store RAMs, entry = {key, count, stamp}
  logic          m_we, p_we;
  logic [IW-1:0] m_waddr, p_waddr;
  logic [EW-1:0] m_wdata, p_wdata, m_rdata, p_rdata;

  crp_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_main_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .rd_en(cmd.rd_en), .raddr(rd_addr), .rdata(m_rdata)
  );

  crp_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_prob_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .rd_en(cmd.rd_en), .raddr(rd_addr), .rdata(p_rdata)
  );

  logic [KW-1:0] m_rkey, p_rkey;
  logic [NW-1:0] m_rcnt, p_rcnt;
  logic [SW-1:0] m_rstamp, p_rstamp;
  assign {m_rkey, m_rcnt, m_rstamp} = m_rdata;
  assign {p_rkey, p_rcnt, p_rstamp} = p_rdata;

  // control state
  logic [SLOTS-1:0] mvalid_r, pvalid_r;
  logic [FW-1:0]    mfill_r, pfill_r;
  logic [SW-1:0]    clock_r;
  logic             eval_r;
  logic [IW-1:0]    eval_idx_r;
  logic [KW-1:0]    key_r;

  // scan trackers
  logic          mhit_r, phit_r, mvic_r, pvic_r, minv_r, pinv_r;
  logic [IW-1:0] mhit_idx_r, phit_idx_r, mvic_idx_r, pvic_idx_r, minv_idx_r, pinv_idx_r;
  logic [NW-1:0] mhit_cnt_r, phit_cnt_r;
  logic [SW-1:0] mvic_met_r, pvic_met_r;
  logic [KW-1:0] mvic_key_r, pvic_key_r;

  logic          m_ok, p_ok;
  logic [SW-1:0] m_met;
  assign m_ok  = mvalid_r[eval_idx_r];
  assign p_ok  = pvalid_r[eval_idx_r];
  assign m_met = lfu ? SW'(m_rcnt) : m_rstamp;

  // per-slot evaluation, one slot a cycle; ascending order keeps lowest on ties
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r  <= in_tdata[KW-1:0];
      mhit_r <= 1'b0;
      phit_r <= 1'b0;
      mvic_r <= 1'b0;
      pvic_r <= 1'b0;
      minv_r <= 1'b0;
      pinv_r <= 1'b0;
    end else if (eval_r) begin
      if (m_ok && m_rkey == key_r && !mhit_r) begin
        mhit_r     <= 1'b1;
        mhit_idx_r <= eval_idx_r;
        mhit_cnt_r <= m_rcnt;
      end
      if (p_ok && p_rkey == key_r && !phit_r) begin
        phit_r     <= 1'b1;
        phit_idx_r <= eval_idx_r;
        phit_cnt_r <= p_rcnt;
      end
      if (m_ok && (!mvic_r || m_met < mvic_met_r)) begin
        mvic_r     <= 1'b1;
        mvic_idx_r <= eval_idx_r;
        mvic_met_r <= m_met;
        mvic_key_r <= m_rkey;
      end
      if (p_ok && (!pvic_r || p_rstamp < pvic_met_r)) begin
        pvic_r     <= 1'b1;
        pvic_idx_r <= eval_idx_r;
        pvic_met_r <= p_rstamp;
        pvic_key_r <= p_rkey;
      end
      if (!m_ok && !minv_r) begin
        minv_r     <= 1'b1;
        minv_idx_r <= eval_idx_r;
      end
      if (!p_ok && !pinv_r) begin
        pinv_r     <= 1'b1;
        pinv_idx_r <= eval_idx_r;
      end
    end
  end

  // insertion targets for each store
  logic          m_full, p_full, m_ev, p_ev, m_grow, p_grow;
  logic [IW-1:0] m_ins, p_ins;
  always_comb begin
    m_full = CW'(mfill_r) >= eff_cap;
    p_full = CW'(pfill_r) >= eff_cap;
    m_ev   = m_full && mvic_r;
    p_ev   = p_full && pvic_r;
    m_ins  = m_ev ? mvic_idx_r : (minv_r ? minv_idx_r : '0);
    p_ins  = p_ev ? pvic_idx_r : (pinv_r ? pinv_idx_r : '0);
    m_grow = !m_ev && !mvalid_r[m_ins];
    p_grow = !p_ev && !pvalid_r[p_ins];
  end

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
    sat_inc = (v == crp_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // update decision
  logic          do_m, do_p, do_mgrow, do_pgrow, do_pclr;
  logic [NW-1:0] new_cnt;
  logic          o_hit, o_tier, o_ev;
  logic [IW-1:0] o_slot;
  logic [KW-1:0] o_evkey;
  always_comb begin
    do_m     = 1'b0;
    do_p     = 1'b0;
    do_mgrow = 1'b0;
    do_pgrow = 1'b0;
    do_pclr  = 1'b0;
    new_cnt  = NW'(1);
    o_hit    = 1'b0;
    o_tier   = 1'b0;
    o_ev     = 1'b0;
    o_slot   = m_ins;
    o_evkey  = '0;
    priority if (mhit_r) begin
      do_m    = 1'b1;
      o_hit   = 1'b1;
      o_slot  = mhit_idx_r;
      new_cnt = sat_inc(mhit_cnt_r);
    end else if (!two || phit_r) begin
      // new main entry, or probation entry promoted with its count
      do_m     = 1'b1;
      do_mgrow = m_grow;
      o_ev     = m_ev;
      o_evkey  = m_ev ? mvic_key_r : '0;
      if (two) begin
        do_pclr = 1'b1;
        o_hit   = 1'b1;
        new_cnt = sat_inc(phit_cnt_r);
      end
    end else begin
      do_p     = 1'b1;
      do_pgrow = p_grow;
      o_tier   = 1'b1;
      o_slot   = p_ins;
      o_ev     = p_ev;
      o_evkey  = p_ev ? pvic_key_r : '0;
    end
  end

  assign m_we    = cmd.commit && do_m;
  assign p_we    = cmd.commit && do_p;
  assign m_waddr = o_slot;
  assign p_waddr = o_slot;
  assign m_wdata = {key_r, new_cnt, clock_r};
  assign p_wdata = {key_r, new_cnt, clock_r};

  // control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r   <= '0;
      pvalid_r   <= '0;
      mfill_r    <= '0;
      pfill_r    <= '0;
      clock_r    <= '0;
      eval_r     <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
      if (cmd.commit) begin
        clock_r    <= clock_r + 1'b1;
        out_tvalid <= 1'b1;
        if (do_m) begin
          mvalid_r[o_slot] <= 1'b1;
        end
        if (do_mgrow) begin
          mfill_r <= mfill_r + 1'b1;
        end
        if (do_p) begin
          pvalid_r[o_slot] <= 1'b1;
        end
        if (do_pgrow) begin
          pfill_r <= pfill_r + 1'b1;
        end
        if (do_pclr) begin
          pvalid_r[phit_idx_r] <= 1'b0;
          if (pfill_r != '0) begin
            pfill_r <= pfill_r - 1'b1;
          end
        end
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= rd_addr;
    if (cmd.commit) begin
      out_tdata <= {7'd0, new_cnt, crp_pkg::IN_KEY_W'(o_evkey), o_ev,
                    crp_pkg::SLOT_W'(o_slot), o_tier, o_hit};
    end
  end

  assign stat.out_free = !out_tvalid || out_tready;

endmodule

// File: sv/cache_replacement_policy.sv
// Sequence: after accept, a slot-by-slot scan over the single read port of each
//   store RAM, then drain and commit; the result is registered at commit, which
//   waits while the result register is full. No new item is taken until idle.
// Reset: synchronous, active low; clears valid bits, fill counts, access
//   clock and configuration (LRU, capacity 64). Entry RAMs are not cleared.
// ---------------------------------------------------------------------------
// cache_replacement_policy
// Fully associative lookup with LRU, LFU and two-tier replacement.
// ---------------------------------------------------------------------------
module cache_replacement_policy #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned KEY_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [crp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [crp_pkg::IN_DATA_W-1:0]      in_tdata,   // access_key
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit, tier, slot[5:0], evicted, evicted_key[47:0], use_count[31:0], pad
  output logic [crp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  crp_pkg::crp_cmd_t        cmd;
  crp_pkg::crp_stat_t       stat;
  logic [$clog2(SLOTS)-1:0] rd_addr;

  crp_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd), .rd_addr(rd_addr)
  );

  crp_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tdata(in_tdata), .cmd(cmd), .rd_addr(rd_addr),
    .stat(stat), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

endmodule

// File: verif/crp_checker.sv
// ---------------------------------------------------------------------------
// crp_checker
// Watches the config port and both streams, predicts each lookup result
// and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module crp_checker
  import crp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int NSLOT = 64;

  typedef struct packed {
    logic [COUNT_W-1:0]  use_count;
    logic [IN_KEY_W-1:0] evicted_key;
    logic                evicted;
    logic [SLOT_W-1:0]   slot;
    logic                tier;
    logic                hit;
  } lookup_t;

  typedef struct {
    bit                 valid [NSLOT];
    bit [IN_KEY_W-1:0]  key   [NSLOT];
    bit [COUNT_W-1:0]   count [NSLOT];
    bit [STAMP_W-1:0]   stamp [NSLOT];
    int                 fill;
  } store_t;

  store_t            main_st, prob_st;
  bit [STAMP_W-1:0]  clock_now;
  bit [MODE_W-1:0]   mode_reg;
  bit [CAP_W-1:0]    cap_reg;
  lookup_t           expected_q [$];

  function automatic int cap_eff();
    int c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > NSLOT) c = NSLOT;
    return c;
  endfunction

  function automatic int find_slot(ref store_t s, input bit [IN_KEY_W-1:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (s.valid[i] && s.key[i] == k) return i;
    return -1;
  endfunction

  // place a key, evicting by stamp or count when the store is full
  function automatic int place(ref store_t s, input bit [IN_KEY_W-1:0] k,
                               input bit [COUNT_W-1:0] cnt, input bit by_count,
                               output bit ev, output bit [IN_KEY_W-1:0] ev_key);
    int sl, best;
    sl = -1;
    ev = 0;
    ev_key = '0;
    if (s.fill >= cap_eff()) begin
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!s.valid[i]) continue;
        if (best < 0) best = i;
        else if (by_count ? (s.count[i] < s.count[best])
                          : (s.stamp[i] < s.stamp[best])) best = i;
      end
      sl = best;
      if (sl >= 0) begin
        ev = 1;
        ev_key = s.key[sl];
      end
    end
    if (sl < 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (!s.valid[i]) begin
          sl = i;
          break;
        end
      if (sl < 0) sl = 0;
      if (!s.valid[sl]) s.fill++;
    end
    s.valid[sl] = 1;
    s.key[sl] = k;
    s.count[sl] = cnt;
    s.stamp[sl] = clock_now;
    return sl;
  endfunction

  function automatic lookup_t predict_lookup(bit [IN_KEY_W-1:0] k);
    lookup_t r;
    int sl, p;
    bit ev;
    bit [IN_KEY_W-1:0] evk;
    bit [COUNT_W-1:0] cnt;
    r = '0;
    cnt = 1;
    ev = 0;
    evk = '0;
    sl = find_slot(main_st, k);
    if (sl >= 0) begin
      r.hit = 1;
      if (main_st.count[sl] != COUNT_MAX) main_st.count[sl]++;
      main_st.stamp[sl] = clock_now;
      cnt = main_st.count[sl];
    end else if (mode_reg != MODE_TWO) begin
      sl = place(main_st, k, 1, mode_reg == MODE_LFU, ev, evk);
    end else begin
      p = find_slot(prob_st, k);
      if (p >= 0) begin
        r.hit = 1;
        cnt = prob_st.count[p];
        if (cnt != COUNT_MAX) cnt++;
        prob_st.valid[p] = 0;
        if (prob_st.fill > 0) prob_st.fill--;
        sl = place(main_st, k, cnt, 0, ev, evk);
      end else begin
        r.tier = 1;
        sl = place(prob_st, k, 1, 0, ev, evk);
      end
    end
    clock_now++;
    r.slot = sl[SLOT_W-1:0];
    r.evicted = ev;
    r.evicted_key = evk;
    r.use_count = cnt;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    lookup_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        main_st.valid[i] = 0;
        prob_st.valid[i] = 0;
      end
      main_st.fill = 0;
      prob_st.fill = 0;
      clock_now = '0;
      mode_reg = MODE_LRU;
      cap_reg = CAP_RESET;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_POLICY_MODE) mode_reg = cfg_wdata[MODE_W-1:0];
        else if (cfg_index == REG_CAPACITY) cap_reg = cfg_wdata[CAP_W-1:0];
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_lookup(in_tdata[IN_KEY_W-1:0]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(lookup_t)-1:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected hit=%b tier=%b slot=%0d ev=%b evk=%h cnt=%0d",
                     $time, exp_r.hit, exp_r.tier, exp_r.slot, exp_r.evicted,
                     exp_r.evicted_key, exp_r.use_count);
            $display("%0t:          actual   hit=%b tier=%b slot=%0d ev=%b evk=%h cnt=%0d",
                     $time, got.hit, got.tier, got.slot, got.evicted,
                     got.evicted_key, got.use_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives keys from small pools through all modes and a range of capacities, with
// random gaps and back-pressure; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
  import crp_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count, pending;
  bit                    long_hold = 0;
  bit                    stim_done = 0;
  logic [IN_KEY_W-1:0]   key_pool [16];

  always #6 clk = ~clk;

  cache_replacement_policy uut (.*);

  crp_checker chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 4);
  endfunction

  // valid stays high straight into the next item when there is no gap
  task automatic send_key(logic [IN_KEY_W-1:0] k);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= k;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // mostly reuse of a small pool, some fresh and extreme keys
  function automatic logic [IN_KEY_W-1:0] pick_key(int pool_n);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return IN_KEY_W'({$urandom, $urandom});
    if (r == 1) return '1;
    if (r == 2) return '0;
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    int modes [7];
    int caps [7];
    int pool_n;
    modes = '{MODE_LRU, MODE_LFU, MODE_TWO, MODE_LRU, 3, MODE_TWO, MODE_LFU};
    caps = '{1, 4, 3, 64, 8, 2, 127};
    for (int i = 0; i < 16; i++) key_pool[i] = IN_KEY_W'({$urandom, $urandom});
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: reset config, extremes, hits, count growth
    send_key('0);
    send_key('1);
    send_key('0);
    send_key(48'h5555_5555_5555);
    send_key(48'hAAAA_AAAA_AAAA);
    send_key('1);
    drain();
    write_reg(REG_POLICY_MODE, MODE_TWO);
    write_reg(REG_CAPACITY, 2);
    send_key(48'h1);
    send_key(48'h2);
    send_key(48'h3);
    send_key(48'h2);
    send_key(48'h3);
    send_key(48'h4);
    send_key(48'h1);
    send_key(48'h1);
    drain();
    // capacity zero (taken as one), below the current fill
    write_reg(REG_CAPACITY, 0);
    write_reg(REG_POLICY_MODE, MODE_LFU);
    send_key(48'h9);
    send_key(48'h9);
    send_key(48'hA);
    drain();
    // random phases
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_POLICY_MODE, modes[ph][MODE_W-1:0]);
      write_reg(REG_CAPACITY, caps[ph][CAP_W-1:0]);
      pool_n = (caps[ph] > 8) ? 16 : $urandom_range(3, 10);
      for (int n = 0; n < 155; n++) begin
        if (ph == 3 && n == 10) long_hold = 1;
        send_key(pick_key(pool_n));
      end
      drain();
    end
    stim_done = 1;
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/crp_pkg.sv
sv/crp_ram.sv
sv/crp_ctrl.sv
sv/crp_dp.sv
sv/cache_replacement_policy.sv
verif/crp_checker.sv
verif/tb.sv
